### design/mst_pkg.sv
`default_nettype none
package mst_pkg;

  localparam int NodeBits    = 7;
  localparam int WeightBits  = 16;
  localparam int MaxNodesDef = 64;
  localparam int MaxEdgesDef = 256;
  localparam logic [NodeBits-1:0] NodeCountRst = NodeBits'(64);

  typedef struct packed {
    logic [NodeBits-1:0]          from_node;
    logic [NodeBits-1:0]          to_node;
    logic signed [WeightBits-1:0] weight;
    logic                         last_edge;
  } mst_in_t;

  typedef struct packed {
    logic                         edge_valid;
    logic [NodeBits-1:0]          tree_from;
    logic [NodeBits-1:0]          tree_to;
    logic signed [WeightBits-1:0] tree_weight;
    logic                         last_result;
    logic                         spanning;
    logic                         overflow;
  } mst_out_t;

  typedef struct packed {
    logic [NodeBits-1:0]   from_node;
    logic [NodeBits-1:0]   to_node;
    logic [WeightBits-1:0] weight;
  } mst_edge_t;

  typedef struct packed {
    logic store;
    logic start;
    logic init_wr;
    logic scan_begin;
    logic scan_run;
    logic take;
    logic find_a;
    logic find_b;
    logic find_step;
    logic link;
    logic emit_begin;
    logic emit_ld;
  } mst_cmd_t;

  typedef struct packed {
    logic init_done;
    logic kept_full;
    logic scan_done;
    logic found;
    logic in_range;
    logic is_root;
    logic out_free;
    logic emit_last;
  } mst_sts_t;

endpackage
`default_nettype wire

### design/mst_ram.sv
`default_nettype none
module mst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### design/mst_ctrl.sv
`default_nettype none
module mst_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  output      logic              in_stall_o,
  input  wire mst_pkg::mst_sts_t sts_i,
  output      mst_pkg::mst_cmd_t cmd_o
);
  import mst_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_SEL  = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_FRD  = 4'd5;
  localparam logic [3:0] S_FCHK = 4'd6;
  localparam logic [3:0] S_LINK = 4'd7;
  localparam logic [3:0] S_EBEG = 4'd8;
  localparam logic [3:0] S_ERD  = 4'd9;
  localparam logic [3:0] S_ELD  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       phase_b_q, phase_b_d;

  assign in_stall_o = (state_q != S_LOAD);

  always_comb begin
    state_d   = state_q;
    phase_b_d = phase_b_q;
    cmd_o     = '0;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (in_last_i) begin
            cmd_o.start = 1'b1;
            state_d     = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_done) state_d = S_SEL;
      end
      S_SEL: begin
        if (sts_i.kept_full) begin
          state_d = S_EBEG;
        end else begin
          cmd_o.scan_begin = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) state_d = S_CHK;
      end
      S_CHK: begin
        if (!sts_i.found) begin
          state_d = S_EBEG;
        end else if (!sts_i.in_range) begin
          // skip edge with a bad endpoint
          cmd_o.take = 1'b1;
          state_d    = S_SEL;
        end else begin
          cmd_o.find_a = 1'b1;
          phase_b_d    = 1'b0;
          state_d      = S_FRD;
        end
      end
      S_FRD: begin
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (!sts_i.is_root) begin
          cmd_o.find_step = 1'b1;
          state_d         = S_FRD;
        end else if (!phase_b_q) begin
          cmd_o.find_b = 1'b1;
          phase_b_d    = 1'b1;
          state_d      = S_FRD;
        end else begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        cmd_o.take = 1'b1;
        state_d    = S_SEL;
      end
      S_EBEG: begin
        cmd_o.emit_begin = 1'b1;
        state_d          = S_ERD;
      end
      S_ERD: begin
        state_d = S_ELD;
      end
      S_ELD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          state_d       = sts_i.emit_last ? S_LOAD : S_ERD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      phase_b_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_b_q <= phase_b_d;
    end
  end

endmodule
`default_nettype wire

### design/mst_dp.sv
`default_nettype none
module mst_dp #(
  parameter int MAX_NODES = mst_pkg::MaxNodesDef,
  parameter int MAX_EDGES = mst_pkg::MaxEdgesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mst_pkg::mst_in_t              in_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [mst_pkg::NodeBits-1:0]  cfg_wdata_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      mst_pkg::mst_out_t             out_data_o,
  input  wire mst_pkg::mst_cmd_t             cmd_i,
  output      mst_pkg::mst_sts_t             sts_o
);
  import mst_pkg::*;

  localparam int EAW = $clog2(MAX_EDGES);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int NAW = $clog2(MAX_NODES);
  localparam int KW  = WeightBits + EAW;
  localparam logic [ECW-1:0]      EdgeMax = ECW'(MAX_EDGES);
  localparam logic [NodeBits-1:0] NodeMax = NodeBits'(MAX_NODES);

  logic [NodeBits-1:0] node_count_q;
  logic [ECW-1:0]      edge_total_q;
  logic                dropped_q;
  logic [NAW-1:0]      init_cnt_q;
  logic [ECW-1:0]      scan_idx_q;
  logic                pend_q;
  logic [EAW-1:0]      pend_idx_q;
  logic                found_q;
  logic [KW-1:0]       best_key_q, prev_key_q;
  logic                have_prev_q;
  mst_edge_t           best_q;
  logic [NodeBits-1:0] cur_q, root_a_q;
  logic [NAW-1:0]      kept_q, k_q;
  logic                out_valid_q;
  mst_out_t            out_q;

  mst_edge_t           edge_wr, edge_rd, kept_rd;
  logic [NodeBits-1:0] par_rd;
  logic [NodeBits-1:0] n_eff;
  logic [NAW-1:0]      need;
  logic [KW-1:0]       cand_key;
  logic                cand_ok;
  logic                roots_differ;
  logic                par_we;
  logic [NAW-1:0]      par_waddr;
  logic [NodeBits-1:0] par_wdata, init_node, root_a_m1, cur_m1;

  assign edge_wr = '{from_node: in_data_i.from_node, to_node: in_data_i.to_node,
                     weight: in_data_i.weight};

  mst_ram #(.WIDTH($bits(mst_edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store && (edge_total_q < EdgeMax)),
    .waddr_i (edge_total_q[EAW-1:0]),
    .wdata_i (edge_wr),
    .raddr_i (scan_idx_q[EAW-1:0]),
    .rdata_o (edge_rd)
  );

  assign roots_differ = (root_a_q != cur_q);
  assign init_node    = NodeBits'(init_cnt_q) + NodeBits'(1);
  assign root_a_m1    = root_a_q - NodeBits'(1);
  assign cur_m1       = cur_q - NodeBits'(1);
  assign par_we       = cmd_i.init_wr || (cmd_i.link && roots_differ);
  assign par_waddr    = cmd_i.init_wr ? init_cnt_q : root_a_m1[NAW-1:0];
  assign par_wdata    = cmd_i.init_wr ? init_node : cur_q;

  mst_ram #(.WIDTH(NodeBits), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (cur_m1[NAW-1:0]),
    .rdata_o (par_rd)
  );

  mst_ram #(.WIDTH($bits(mst_edge_t)), .DEPTH(MAX_NODES)) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.link && roots_differ),
    .waddr_i (kept_q),
    .wdata_i (best_q),
    .raddr_i (k_q),
    .rdata_o (kept_rd)
  );

  always_comb begin
    if (node_count_q == '0)          n_eff = NodeBits'(1);
    else if (node_count_q > NodeMax) n_eff = NodeMax;
    else                             n_eff = node_count_q;
  end
  assign need = NAW'(n_eff - NodeBits'(1));

  // order key: signed weight made unsigned, arrival index breaks ties
  assign cand_key = {~edge_rd.weight[WeightBits-1], edge_rd.weight[WeightBits-2:0], pend_idx_q};
  assign cand_ok  = (!have_prev_q || (cand_key > prev_key_q)) &&
                    (!found_q || (cand_key < best_key_q));

  always_comb begin
    sts_o           = '0;
    sts_o.init_done = (init_cnt_q == NAW'(MAX_NODES - 1));
    sts_o.kept_full = (kept_q == need);
    sts_o.scan_done = !pend_q && (scan_idx_q == edge_total_q);
    sts_o.found     = found_q;
    sts_o.in_range  = (best_q.from_node != '0) && (best_q.from_node <= n_eff) &&
                      (best_q.to_node != '0) && (best_q.to_node <= n_eff);
    sts_o.is_root   = (par_rd == cur_q);
    sts_o.out_free  = !out_valid_q || !out_stall_i;
    sts_o.emit_last = (kept_q == '0) || ((k_q + NAW'(1)) == kept_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountRst;
      edge_total_q <= '0;
      dropped_q    <= 1'b0;
      init_cnt_q   <= '0;
      scan_idx_q   <= '0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      have_prev_q  <= 1'b0;
      kept_q       <= '0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
      if (cmd_i.store) begin
        if (edge_total_q < EdgeMax) edge_total_q <= edge_total_q + ECW'(1);
        else                        dropped_q    <= 1'b1;
      end
      if (cmd_i.start) begin
        init_cnt_q  <= '0;
        have_prev_q <= 1'b0;
        kept_q      <= '0;
      end
      if (cmd_i.init_wr) init_cnt_q <= init_cnt_q + NAW'(1);
      if (cmd_i.scan_begin) begin
        scan_idx_q <= '0;
        pend_q     <= 1'b0;
        found_q    <= 1'b0;
      end
      if (cmd_i.scan_run) begin
        pend_q <= (scan_idx_q < edge_total_q);
        if (scan_idx_q < edge_total_q) scan_idx_q <= scan_idx_q + ECW'(1);
        if (pend_q && cand_ok) found_q <= 1'b1;
      end
      if (cmd_i.take) have_prev_q <= 1'b1;
      if (cmd_i.link && roots_differ) kept_q <= kept_q + NAW'(1);
      if (cmd_i.emit_begin) k_q <= '0;
      if (cmd_i.emit_ld) begin
        out_valid_q <= 1'b1;
        k_q         <= k_q + NAW'(1);
        if (sts_o.emit_last) begin
          edge_total_q <= '0;
          dropped_q    <= 1'b0;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_run) pend_idx_q <= scan_idx_q[EAW-1:0];
    if (cmd_i.scan_run && pend_q && cand_ok) begin
      best_key_q <= cand_key;
      best_q     <= edge_rd;
    end
    if (cmd_i.take)      prev_key_q <= best_key_q;
    if (cmd_i.find_a)    cur_q      <= best_q.from_node;
    if (cmd_i.find_step) cur_q      <= par_rd;
    if (cmd_i.find_b) begin
      root_a_q <= cur_q;
      cur_q    <= best_q.to_node;
    end
    if (cmd_i.emit_ld) begin
      out_q.edge_valid  <= (kept_q != '0);
      out_q.tree_from   <= (kept_q != '0) ? kept_rd.from_node : '0;
      out_q.tree_to     <= (kept_q != '0) ? kept_rd.to_node : '0;
      out_q.tree_weight <= (kept_q != '0) ? kept_rd.weight : '0;
      out_q.last_result <= sts_o.emit_last;
      out_q.spanning    <= sts_o.kept_full;
      out_q.overflow    <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### design/minimum_spanning_tree.sv
`default_nettype none
// Kruskal minimum spanning tree engine.
// Input channel (in_valid_i / in_stall_o / in_data_i): one edge per beat, one
// beat per cycle while loading. The beat with last_edge set starts the run;
// input stalls until every result of the run has been handed to the output
// register. Edges beyond MAX_EDGES are dropped and reported as overflow.
// Output channel (out_valid_o / out_stall_i / out_data_o): the kept tree edges
// in ascending weight order, one beat each, the final one with last_result.
// An empty result (edge_valid low) is sent when no edge is kept.
// After the last edge the forest is reset, then each selection makes one pass
// over the edge memory, plus a root walk per endpoint when the edge is in range,
// and finally the result beats are emitted. The edge memory's single read port
// sets the scan cost.
// A stalled receiver holds the current beat; the engine waits on it.
// Reset clears counts and control; node_count returns to 64.
// cfg_we_i writes node_count; write it only between runs.
module minimum_spanning_tree #(
  parameter int MAX_NODES = mst_pkg::MaxNodesDef,
  parameter int MAX_EDGES = mst_pkg::MaxEdgesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire mst_pkg::mst_in_t             in_data_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      mst_pkg::mst_out_t            out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [mst_pkg::NodeBits-1:0] cfg_wdata_i
);
  import mst_pkg::*;

  mst_cmd_t cmd;
  mst_sts_t sts;

  mst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_edge),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mst_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

### design/mst_checker.sv
`default_nettype none
module mst_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire mst_pkg::mst_in_t             in_data_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire mst_pkg::mst_out_t            out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_edge |=> in_stall_o)
    else $error("input not stalled after last edge");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.edge_valid |-> out_data_o.last_result)
    else $error("empty result not marked last");

  a_nodes_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.edge_valid |->
      (out_data_o.tree_from != '0) && (out_data_o.tree_to != '0))
    else $error("tree edge with node zero");

endmodule

bind minimum_spanning_tree mst_checker u_mst_checker (.*);
`default_nettype wire

### verif/tb_minimum_spanning_tree.sv
`timescale 1ns / 1ps
module tb_minimum_spanning_tree;
  import mst_pkg::*;

  typedef enum logic [1:0] {ItemEdge, ItemCfg, ItemSync, ItemHold} item_kind_e;

  typedef struct {
    item_kind_e kind;
    mst_in_t    edge_beat;
    logic [NodeBits-1:0] cfg_val;
  } item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  mst_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  mst_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [NodeBits-1:0] cfg_wdata_i = '0;

  minimum_spanning_tree u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  item_t    pending_q[$];
  mst_out_t tree_q[$];
  int       errors = 0;
  int       quiet_cycles = 0;
  int       cyc = 0;
  bit       beat_taken = 0;
  int       hold_reqs = 0;
  int       holds_seen = 0;

  // predictor copy of the block's state
  logic [NodeBits-1:0]          g_from[$];
  logic [NodeBits-1:0]          g_to[$];
  logic signed [WeightBits-1:0] g_weight[$];
  bit                           g_dropped = 0;
  logic [NodeBits-1:0]          nodes_reg = NodeCountRst;

  initial forever #1 clk_i = ~clk_i;

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (((cyc / 500) % 4) == 0) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int root_walk(ref int par[0:64], input int node);
    int steps;
    steps = 0;
    while (par[node] != node && steps <= 64) begin
      node = par[node];
      steps++;
    end
    return node;
  endfunction

  // Kruskal over the stored graph; push every expected result beat
  function automatic void kruskal_predict();
    int n, need, kept, cur, j, a, b, p, q;
    int ord[$];
    int par[0:64];
    mst_out_t r;
    bit span;
    mst_out_t found[$];
    n = nodes_reg;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    need = n - 1;
    for (int i = 0; i <= 64; i++) par[i] = i;
    for (int i = 0; i < g_from.size(); i++) begin
      j = ord.size();
      while (j > 0 && g_weight[ord[j-1]] > g_weight[i]) j--;
      ord.insert(j, i);
    end
    kept = 0;
    for (int i = 0; i < ord.size() && kept < need; i++) begin
      cur = ord[i];
      a = g_from[cur];
      b = g_to[cur];
      if (a < 1 || a > n || b < 1 || b > n) continue;
      p = root_walk(par, a);
      q = root_walk(par, b);
      if (p != q) begin
        par[p] = q;
        r = '0;
        r.edge_valid = 1'b1;
        r.tree_from = g_from[cur];
        r.tree_to = g_to[cur];
        r.tree_weight = g_weight[cur];
        found.insert(found.size(), r);
        kept++;
      end
    end
    span = (kept == need);
    if (kept == 0) begin
      r = '0;
      found.insert(found.size(), r);
    end
    found[found.size()-1].last_result = 1'b1;
    foreach (found[i]) begin
      found[i].spanning = span;
      found[i].overflow = g_dropped;
      tree_q.insert(tree_q.size(), found[i]);
    end
    g_from.delete();
    g_to.delete();
    g_weight.delete();
    g_dropped = 0;
  endfunction

  // monitor and predictor at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc++;
      beat_taken = in_valid_i && !in_stall_o;
      if (cfg_we_i) nodes_reg = cfg_wdata_i;
      if (beat_taken) begin
        if (g_from.size() < MaxEdgesDef) begin
          g_from.insert(g_from.size(), in_data_i.from_node);
          g_to.insert(g_to.size(), in_data_i.to_node);
          g_weight.insert(g_weight.size(), in_data_i.weight);
        end else begin
          g_dropped = 1;
        end
        if (in_data_i.last_edge) kruskal_predict();
      end
      if (out_valid_o && !out_stall_i) begin
        if (tree_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %p", $time, out_data_o);
          errors++;
        end else begin
          if (out_data_o.edge_valid !== tree_q[0].edge_valid ||
              out_data_o.tree_from !== tree_q[0].tree_from ||
              out_data_o.tree_to !== tree_q[0].tree_to ||
              out_data_o.tree_weight !== tree_q[0].tree_weight ||
              out_data_o.last_result !== tree_q[0].last_result ||
              out_data_o.spanning !== tree_q[0].spanning ||
              out_data_o.overflow !== tree_q[0].overflow) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, tree_q[0], out_data_o);
            errors++;
          end
          void'(tree_q.pop_front());
        end
      end
      if (tree_q.size() == 0) quiet_cycles++;
      else quiet_cycles = 0;
    end
  end

  // driver
  int gap = 0;
  always @(negedge clk_i) begin
    logic nv;
    mst_in_t nd;
    logic nwe;
    logic [NodeBits-1:0] nw;
    nv = in_valid_i;
    nd = in_data_i;
    nwe = 1'b0;
    nw = cfg_wdata_i;
    if (rst_ni && !(in_valid_i && !beat_taken)) begin
      nv = 1'b0;
      if (gap > 0) begin
        gap--;
      end else if (pending_q.size() > 0) begin
        case (pending_q[0].kind)
          ItemEdge: begin
            nv = 1'b1;
            nd = pending_q[0].edge_beat;
            gap = pick_idle();
            void'(pending_q.pop_front());
          end
          ItemCfg: begin
            if (quiet_cycles >= 20 && !cfg_we_i) begin
              nwe = 1'b1;
              nw = pending_q[0].cfg_val;
              void'(pending_q.pop_front());
            end
          end
          ItemSync: begin
            if (quiet_cycles >= 20) void'(pending_q.pop_front());
          end
          ItemHold: begin
            hold_reqs++;
            void'(pending_q.pop_front());
          end
          default: begin
            void'(pending_q.pop_front());
          end
        endcase
      end
    end
    if (rst_ni) beat_taken = 0;
    in_valid_i <= nv;
    in_data_i <= nd;
    cfg_we_i <= nwe;
    cfg_wdata_i <= nw;
  end

  // receiver stall
  int stall_left = 0;
  always @(negedge clk_i) begin
    logic ns;
    ns = 1'b0;
    if (hold_reqs != holds_seen) begin
      holds_seen = hold_reqs;
      stall_left = 800;
    end
    if (stall_left > 0) begin
      stall_left--;
      ns = 1'b1;
    end else if ($urandom_range(0, 1) == 1) begin
      stall_left = pick_idle();
    end
    out_stall_i <= ns;
  end

  task automatic add_edge(input int f, input int t, input int w, input bit last);
    item_t it;
    it.kind = ItemEdge;
    it.cfg_val = '0;
    it.edge_beat.from_node = f[NodeBits-1:0];
    it.edge_beat.to_node = t[NodeBits-1:0];
    it.edge_beat.weight = w[WeightBits-1:0];
    it.edge_beat.last_edge = last;
    pending_q.insert(pending_q.size(), it);
  endtask

  task automatic add_ctrl(input item_kind_e k, input int v);
    item_t it;
    it.kind = k;
    it.cfg_val = v[NodeBits-1:0];
    it.edge_beat = '0;
    pending_q.insert(pending_q.size(), it);
  endtask

  task automatic add_graph(input int n, input int cnt);
    int f, t, w;
    bit ties;
    ties = ($urandom_range(0, 1) == 1);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 9) == 0) f = $urandom_range(0, 127);
      else f = $urandom_range(1, n);
      if ($urandom_range(0, 9) == 0) t = $urandom_range(0, 127);
      else t = $urandom_range(1, n);
      w = ties ? $urandom_range(0, 3) - 2 : $urandom_range(0, 65535);
      add_edge(f, t, w, i == cnt - 1);
    end
  endtask

  initial begin
    int total, n, cnt;
    // directed part
    add_edge(1, 64, -32768, 1);
    add_ctrl(ItemCfg, 4);
    add_edge(2, 2, -5, 0);
    add_edge(0, 3, -9, 0);
    add_edge(1, 5, -9, 0);
    add_edge(127, 1, -9, 0);
    add_edge(1, 2, 7, 0);
    add_edge(3, 4, 7, 0);
    add_edge(2, 3, 32767, 0);
    add_edge(4, 1, 32767, 1);
    add_ctrl(ItemCfg, 0);
    add_edge(1, 1, 100, 1);
    add_ctrl(ItemCfg, 127);
    add_edge(10, 20, -1, 0);
    add_edge(64, 63, 0, 1);
    add_ctrl(ItemCfg, 1);
    add_edge(1, 2, 3, 1);
    add_ctrl(ItemCfg, 3);
    add_edge(1, 2, 5, 0);
    add_edge(1, 2, 4, 1);
    // store overflow, last edge itself dropped
    add_ctrl(ItemCfg, 8);
    add_graph(8, 257);
    // random part
    total = 0;
    while (total < 120) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: n = 0;
          1: n = $urandom_range(65, 127);
          2: n = 64;
          default: n = $urandom_range(1, 16);
        endcase
        add_ctrl(ItemCfg, n);
      end else begin
        n = $urandom_range(2, 16);
      end
      if (n < 1) n = 1;
      if (n > 64) n = 64;
      cnt = $urandom_range(1, 14);
      add_graph(n, cnt);
      total += cnt;
      if (total > 40 && total < 56) add_ctrl(ItemSync, 0);
      if (total > 80 && total < 96) add_ctrl(ItemHold, 0);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_q.size() == 0 && !in_valid_i);
    wait (tree_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && tree_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

endmodule
